// ===== hdl/pbd_pkg.sv =====
package pbd_pkg;

    localparam int ROWS      = 720;
    localparam int ROW_BYTES = 72;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 10;
    localparam int LEN_W  = 18;
    localparam int CFG_W  = LEN_W;
    localparam int CFG_INDEX_W = 1;

    // wide enough to hold ROW_BYTES and a column sum before clipping
    localparam int SPAN_W = COL_W + 1;
    // wide enough to hold ROWS
    localparam int ROWC_W = ROW_W + 1;

    localparam logic [SPAN_W-1:0] ROW_BYTES_V = SPAN_W'(ROW_BYTES);
    localparam logic [ROWC_W-1:0] ROWS_V      = ROWC_W'(ROWS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(ROW_BYTES - 1);
    localparam logic [LEN_W-1:0]  CONSUMED_MAX = '1;

    localparam logic [BYTE_W-1:0] RUN_HEADER_MIN = 8'h81;
    localparam logic [BYTE_W:0]   RUN_BASE       = 9'h101;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ONLY    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_LIT    = 2'd2,
        PH_FULL   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FS_RUNNING = 2'd0,
        FS_DONE    = 2'd1,
        FS_TRUNC   = 2'd2,
        FS_OVER    = 2'd3
    } finish_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_TRUNC    = 2'd1,
        ERR_OVERFLOW = 2'd2
    } error_t;

    typedef struct packed {
        phase_t              phase;
        logic [BYTE_W-1:0]   literal_left;
        logic [BYTE_W-1:0]   run_length;
        logic [COL_W-1:0]    column_count;
        logic [ROW_W-1:0]    row_count;
        logic [LEN_W-1:0]    bytes_consumed;
        finish_t             finish;
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   pixel_byte;
        logic [BYTE_W-1:0]   repeat_count;
        logic [ROW_W-1:0]    row_index;
        logic [COL_W-1:0]    column_byte;
        logic                image_done;
        error_t              error_code;
    } result_t;

    typedef struct packed {
        logic                check_only;
        logic [LEN_W-1:0]    stream_length;
    } cfg_t;

endpackage

// ===== hdl/packbits_bitmap_row_decoder.sv =====
// Channel  Direction  Handshake           Payload
// in       into       in_valid/in_stall   packed_byte
// out      out of     out_valid/out_stall pixel_byte, repeat_count, row_index,
//                                         column_byte, image_done, error_code
// cfg      into       cfg_write           cfg_index, cfg_data
//
// One item per cycle sustained while no result is held back by a stalled output. An item is held in
// the input register, is decoded by the step logic, and its result lands in the
// output register when the item advances; out_valid rises with that result.
// Reset clears the decode state, the configuration and both valid flags.
// A stalled output only blocks items that would make a result.
module packbits_bitmap_row_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pbd_pkg::BYTE_W-1:0]          packed_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pbd_pkg::BYTE_W-1:0]          pixel_byte,
    output logic [pbd_pkg::BYTE_W-1:0]          repeat_count,
    output logic [pbd_pkg::ROW_W-1:0]           row_index,
    output logic [pbd_pkg::COL_W-1:0]           column_byte,
    output logic                                image_done,
    output logic [1:0]                          error_code,
    input  logic                                cfg_write,
    input  logic [pbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pbd_pkg::CFG_W-1:0]           cfg_data
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [pbd_pkg::BYTE_W-1:0]    in_byte_reg;
    logic [pbd_pkg::BYTE_W-1:0]    in_byte_next;
    pbd_pkg::state_t               state_reg;
    pbd_pkg::state_t               state_next;
    pbd_pkg::state_t               step_state;
    pbd_pkg::cfg_t                 cfg_reg;
    pbd_pkg::cfg_t                 cfg_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    pbd_pkg::result_t              result_reg;
    pbd_pkg::result_t              result_next;
    pbd_pkg::result_t              step_result;
    logic                          step_emit;
    logic                          advance;
    logic                          load_in;

    pbd_step u_step (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .packed_byte (in_byte_reg),
        .state_next  (step_state),
        .result      (step_result),
        .emit        (step_emit)
    );

    // an item with no result need not wait for the output register
    assign advance  = in_valid_reg && (!step_emit || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        cfg_next       = cfg_reg;

        if (advance)
        begin
            in_valid_next = 1'b0;
            state_next    = step_state;
        end
        if (load_in)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = packed_byte;
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (advance && step_emit)
        begin
            out_valid_next = 1'b1;
            result_next    = step_result;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                pbd_pkg::CFG_CHECK_ONLY:    cfg_next.check_only    = cfg_data[0];
                pbd_pkg::CFG_STREAM_LENGTH: cfg_next.stream_length = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg <= '0;
            state_reg.phase          <= pbd_pkg::PH_HEADER;
            state_reg.literal_left   <= '0;
            state_reg.run_length     <= '0;
            state_reg.column_count   <= '0;
            state_reg.row_count      <= '0;
            state_reg.bytes_consumed <= '0;
            state_reg.finish         <= pbd_pkg::FS_RUNNING;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        result_reg  <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_byte   = result_reg.pixel_byte;
    assign repeat_count = result_reg.repeat_count;
    assign row_index    = result_reg.row_index;
    assign column_byte  = result_reg.column_byte;
    assign image_done   = result_reg.image_done;
    assign error_code   = result_reg.error_code;

endmodule

// ===== hdl/pbd_step.sv =====
module pbd_step (
    input  pbd_pkg::state_t                  state,
    input  pbd_pkg::cfg_t                    cfg,
    input  logic [pbd_pkg::BYTE_W-1:0]       packed_byte,
    output pbd_pkg::state_t                  state_next,
    output pbd_pkg::result_t                 result,
    output logic                             emit
);

    always_comb
    begin
        logic [pbd_pkg::LEN_W:0]      need_hdr;
        logic [pbd_pkg::LEN_W:0]      need_lit;
        logic [pbd_pkg::LEN_W:0]      avail;
        logic [pbd_pkg::LEN_W-1:0]    consumed_inc;
        logic [pbd_pkg::SPAN_W-1:0]   space;
        logic [pbd_pkg::SPAN_W-1:0]   col_wide;
        logic [pbd_pkg::SPAN_W-1:0]   col_sum;
        logic [pbd_pkg::ROWC_W-1:0]   row_inc;
        logic [pbd_pkg::BYTE_W-1:0]   cnt;
        logic                         do_advance;
        logic                         done;
        logic                         overflow;

        state_next = state;
        emit       = 1'b0;
        result.pixel_byte   = '0;
        result.repeat_count = '0;
        result.row_index    = state.row_count;
        result.column_byte  = state.column_count;
        result.image_done   = 1'b0;
        result.error_code   = pbd_pkg::ERR_OK;

        avail        = {1'b0, cfg.stream_length};
        consumed_inc = (state.bytes_consumed < pbd_pkg::CONSUMED_MAX)
                     ? state.bytes_consumed + pbd_pkg::LEN_W'(1)
                     : state.bytes_consumed;
        need_hdr = {1'b0, state.bytes_consumed} + (pbd_pkg::LEN_W+1)'(2);
        need_lit = {1'b0, consumed_inc} + (pbd_pkg::LEN_W+1)'(packed_byte)
                 + (pbd_pkg::LEN_W+1)'(1);
        col_wide = {1'b0, state.column_count};
        space    = pbd_pkg::ROW_BYTES_V - col_wide;
        row_inc  = {1'b0, state.row_count} + pbd_pkg::ROWC_W'(1);
        col_sum    = col_wide + pbd_pkg::SPAN_W'(1);
        cnt        = pbd_pkg::BYTE_W'(1);
        do_advance = 1'b0;
        done       = 1'b0;
        overflow   = 1'b0;

        if (state.finish == pbd_pkg::FS_RUNNING)
        begin
            unique case (state.phase)
                pbd_pkg::PH_HEADER:
                begin
                    if (need_hdr > avail)
                    begin
                        state_next.finish = pbd_pkg::FS_TRUNC;
                        emit              = 1'b1;
                        result.error_code = pbd_pkg::ERR_TRUNC;
                    end
                    else
                    begin
                        state_next.bytes_consumed = consumed_inc;
                        if (packed_byte >= pbd_pkg::RUN_HEADER_MIN)
                        begin
                            state_next.run_length = pbd_pkg::BYTE_W'(
                                pbd_pkg::RUN_BASE - {1'b0, packed_byte});
                            state_next.phase = pbd_pkg::PH_RUN;
                        end
                        else if (need_lit > avail)
                        begin
                            state_next.finish = pbd_pkg::FS_TRUNC;
                            emit              = 1'b1;
                            result.error_code = pbd_pkg::ERR_TRUNC;
                        end
                        else
                        begin
                            state_next.literal_left = packed_byte;
                            state_next.phase        = pbd_pkg::PH_LIT;
                        end
                    end
                end

                pbd_pkg::PH_RUN:
                begin
                    state_next.bytes_consumed = consumed_inc;
                    state_next.phase          = pbd_pkg::PH_HEADER;
                    cnt = state.run_length;
                    if ({1'b0, cnt} > {1'b0, space})
                    begin
                        if (!cfg.check_only)
                        begin
                            // clip to the row and stop
                            overflow            = 1'b1;
                            state_next.finish   = pbd_pkg::FS_OVER;
                            emit                = 1'b1;
                            result.pixel_byte   = packed_byte;
                            result.repeat_count = pbd_pkg::BYTE_W'(space);
                            result.error_code   = pbd_pkg::ERR_OVERFLOW;
                        end
                        col_sum = pbd_pkg::ROW_BYTES_V;
                    end
                    else
                    begin
                        col_sum = col_wide + pbd_pkg::SPAN_W'(cnt);
                    end
                    do_advance = !overflow;
                end

                pbd_pkg::PH_LIT:
                begin
                    state_next.bytes_consumed = consumed_inc;
                    if (state.literal_left == '0)
                    begin
                        state_next.phase = pbd_pkg::PH_HEADER;
                        do_advance       = 1'b1;
                    end
                    else
                    begin
                        state_next.literal_left = state.literal_left - pbd_pkg::BYTE_W'(1);
                        if (col_sum >= pbd_pkg::ROW_BYTES_V)
                            state_next.phase = pbd_pkg::PH_FULL;
                        else
                            state_next.column_count = pbd_pkg::COL_W'(col_sum);
                    end
                end

                pbd_pkg::PH_FULL:
                begin
                    // row is full while literal bytes remain
                    state_next.bytes_consumed = consumed_inc;
                    state_next.finish  = pbd_pkg::FS_OVER;
                    emit               = 1'b1;
                    result.column_byte = pbd_pkg::LAST_COL;
                    result.error_code  = pbd_pkg::ERR_OVERFLOW;
                    overflow           = 1'b1;
                end

                default:
                begin
                    state_next = state;
                end
            endcase

            if (do_advance)
            begin
                if (col_sum >= pbd_pkg::ROW_BYTES_V)
                begin
                    state_next.column_count = '0;
                    state_next.row_count    = pbd_pkg::ROW_W'(row_inc);
                    if (row_inc >= pbd_pkg::ROWS_V)
                    begin
                        state_next.finish = pbd_pkg::FS_DONE;
                        done              = 1'b1;
                    end
                end
                else
                begin
                    state_next.column_count = pbd_pkg::COL_W'(col_sum);
                end
            end

            if ((state.phase == pbd_pkg::PH_RUN || state.phase == pbd_pkg::PH_LIT)
                && !overflow)
            begin
                if (!cfg.check_only)
                begin
                    emit                = 1'b1;
                    result.pixel_byte   = packed_byte;
                    result.repeat_count = cnt;
                    result.image_done   = done;
                end
                else if (done)
                begin
                    emit              = 1'b1;
                    result.image_done = 1'b1;
                end
            end
        end
    end

endmodule

// ===== tb/sv/packbits_bitmap_row_decoder_tb.sv =====
module packbits_bitmap_row_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 10;
    localparam int MAX_RUN        = int'(pbd_pkg::RUN_BASE) - int'(pbd_pkg::RUN_HEADER_MIN);
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BYTES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        END_HEADER_TRUNC,
        END_LITERAL_TRUNC,
        END_RUN_OVERFLOW,
        END_LITERAL_OVERFLOW,
        END_IMAGE_DONE
    } ending_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic [pbd_pkg::BYTE_W-1:0]      packed_byte  = '0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic [pbd_pkg::BYTE_W-1:0]      pixel_byte;
    logic [pbd_pkg::BYTE_W-1:0]      repeat_count;
    logic [pbd_pkg::ROW_W-1:0]       row_index;
    logic [pbd_pkg::COL_W-1:0]       column_byte;
    logic                            image_done;
    logic [1:0]                      error_code;
    logic                            cfg_write    = 1'b0;
    logic [pbd_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [pbd_pkg::CFG_W-1:0]       cfg_data     = '0;

    // decoder state as seen by the predictor
    pbd_pkg::phase_t                 ph_now       = pbd_pkg::PH_HEADER;
    logic [pbd_pkg::BYTE_W-1:0]      lit_rest     = '0;
    logic [pbd_pkg::BYTE_W-1:0]      run_cnt      = '0;
    logic [pbd_pkg::SPAN_W-1:0]      col_pos      = '0;
    logic [pbd_pkg::ROWC_W-1:0]      row_pos      = '0;
    logic [pbd_pkg::LEN_W-1:0]       byte_total   = '0;
    pbd_pkg::finish_t                fin_state    = pbd_pkg::FS_RUNNING;
    logic                            check_mode   = 1'b0;
    logic [pbd_pkg::LEN_W-1:0]       length_limit = '0;

    pbd_pkg::result_t                decoded_due[$];

    int                              mismatches   = 0;
    int                              bytes_sent   = 0;
    int                              quiet_cycles = 0;
    int                              hold_len     = 0;
    bit                              calm         = 1'b0;

    packbits_bitmap_row_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packed_byte  (packed_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_byte   (pixel_byte),
        .repeat_count (repeat_count),
        .row_index    (row_index),
        .column_byte  (column_byte),
        .image_done   (image_done),
        .error_code   (error_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void push_result(input logic [pbd_pkg::BYTE_W-1:0] pix,
                                        input logic [pbd_pkg::BYTE_W-1:0] cnt,
                                        input logic [pbd_pkg::ROW_W-1:0] r,
                                        input logic [pbd_pkg::COL_W-1:0] c,
                                        input logic done,
                                        input pbd_pkg::error_t err);
        pbd_pkg::result_t res;
        res.pixel_byte   = pix;
        res.repeat_count = cnt;
        res.row_index    = r;
        res.column_byte  = c;
        res.image_done   = done;
        res.error_code   = err;
        decoded_due.push_back(res);
    endfunction

    function automatic void take_byte();
        if (byte_total != pbd_pkg::CONSUMED_MAX)
            byte_total = byte_total + 1'b1;
    endfunction

    // close the row once it is full; 1 when that was the last row
    function automatic logic end_row();
        if (col_pos >= pbd_pkg::ROW_BYTES_V)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            if (row_pos >= pbd_pkg::ROWS_V)
            begin
                fin_state = pbd_pkg::FS_DONE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [pbd_pkg::BYTE_W-1:0] b);
        logic [pbd_pkg::SPAN_W-1:0] space;
        logic [pbd_pkg::BYTE_W-1:0] cnt;
        logic [pbd_pkg::ROW_W-1:0]  row0;
        logic [pbd_pkg::COL_W-1:0]  col0;
        logic                       done;
        row0 = row_pos[pbd_pkg::ROW_W-1:0];
        col0 = col_pos[pbd_pkg::COL_W-1:0];
        cnt  = '0;
        done = 1'b0;
        if (fin_state != pbd_pkg::FS_RUNNING)
            return;
        case (ph_now)
            pbd_pkg::PH_HEADER:
            begin
                if (int'(byte_total) + 2 > int'(length_limit))
                begin
                    fin_state = pbd_pkg::FS_TRUNC;
                    push_result('0, '0, row0, col0, 1'b0, pbd_pkg::ERR_TRUNC);
                    return;
                end
                take_byte();
                if (b >= pbd_pkg::RUN_HEADER_MIN)
                begin
                    run_cnt = pbd_pkg::BYTE_W'(pbd_pkg::RUN_BASE - {1'b0, b});
                    ph_now  = pbd_pkg::PH_RUN;
                end
                else if (int'(byte_total) + int'(b) + 1 > int'(length_limit))
                begin
                    fin_state = pbd_pkg::FS_TRUNC;
                    push_result('0, '0, row0, col0, 1'b0, pbd_pkg::ERR_TRUNC);
                end
                else
                begin
                    lit_rest = b;
                    ph_now   = pbd_pkg::PH_LIT;
                end
                return;
            end
            pbd_pkg::PH_RUN:
            begin
                space = pbd_pkg::ROW_BYTES_V - col_pos;
                take_byte();
                ph_now = pbd_pkg::PH_HEADER;
                cnt    = run_cnt;
                if (cnt > space)
                begin
                    if (!check_mode)
                    begin
                        fin_state = pbd_pkg::FS_OVER;
                        push_result(b, pbd_pkg::BYTE_W'(space), row0, col0, 1'b0,
                                    pbd_pkg::ERR_OVERFLOW);
                        return;
                    end
                    col_pos = pbd_pkg::ROW_BYTES_V;
                end
                else
                    col_pos = col_pos + cnt;
                done = end_row();
            end
            pbd_pkg::PH_LIT:
            begin
                take_byte();
                cnt = pbd_pkg::BYTE_W'(1);
                if (lit_rest == '0)
                begin
                    ph_now  = pbd_pkg::PH_HEADER;
                    col_pos = col_pos + 1'b1;
                    done    = end_row();
                end
                else
                begin
                    lit_rest = lit_rest - 1'b1;
                    // park on the last column; the next literal byte overflows
                    if (col_pos + pbd_pkg::SPAN_W'(1) >= pbd_pkg::ROW_BYTES_V)
                        ph_now = pbd_pkg::PH_FULL;
                    else
                        col_pos = col_pos + 1'b1;
                end
            end
            default:
            begin
                take_byte();
                fin_state = pbd_pkg::FS_OVER;
                push_result('0, '0, row0, pbd_pkg::LAST_COL, 1'b0, pbd_pkg::ERR_OVERFLOW);
                return;
            end
        endcase
        if (!check_mode)
            push_result(b, cnt, row0, col0, done, pbd_pkg::ERR_OK);
        else if (done)
            push_result('0, '0, row0, col0, 1'b1, pbd_pkg::ERR_OK);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // sample at the falling edge: these values hold through the next rising edge
    always @(negedge clk)
    begin : result_check
        pbd_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_due.size() == 0)
                    report_mismatch("unexpected result, pixel_byte", int'(pixel_byte), -1);
                else
                begin
                    want = decoded_due.pop_front();
                    if (pixel_byte !== want.pixel_byte)
                        report_mismatch("pixel_byte", int'(pixel_byte),
                                        int'(want.pixel_byte));
                    if (repeat_count !== want.repeat_count)
                        report_mismatch("repeat_count", int'(repeat_count),
                                        int'(want.repeat_count));
                    if (row_index !== want.row_index)
                        report_mismatch("row_index", int'(row_index),
                                        int'(want.row_index));
                    if (column_byte !== want.column_byte)
                        report_mismatch("column_byte", int'(column_byte),
                                        int'(want.column_byte));
                    if (image_done !== want.image_done)
                        report_mismatch("image_done", int'(image_done),
                                        int'(want.image_done));
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", int'(error_code),
                                        int'(want.error_code));
                end
            end
            if (in_valid && !in_stall)
                decode_byte(packed_byte);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : result_stall
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else
                n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    function automatic logic [pbd_pkg::BYTE_W-1:0] run_header(input int n);
        return pbd_pkg::BYTE_W'(int'(pbd_pkg::RUN_BASE) - n);
    endfunction

    function automatic logic [pbd_pkg::BYTE_W-1:0] lit_header(input int n);
        return pbd_pkg::BYTE_W'(n - 1);
    endfunction

    // mostly short runs and literals, now and then up to the limit
    function automatic int size_pick(input int lo, input int hi);
        int top;
        top = (hi < lo + 7) ? hi : lo + 7;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(lo, top);
        return $urandom_range(lo, hi);
    endfunction

    // leave valid high after acceptance; the next item or a gap decides
    task automatic send_byte(input logic [pbd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        packed_byte <= b;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain_decoder();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        // items with no result may still be in the pipeline
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic co, input logic [pbd_pkg::LEN_W-1:0] len);
        cfg_write <= 1'b1;
        cfg_index <= pbd_pkg::CFG_CHECK_ONLY;
        cfg_data  <= pbd_pkg::CFG_W'(co);
        @(posedge clk);
        cfg_index <= pbd_pkg::CFG_STREAM_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        check_mode   = co;
        length_limit = len;
    endtask

    // one full row of runs and literals, starting at column zero
    task automatic send_row(input logic co_mode);
        int c;
        int rem;
        int n;
        c = 0;
        while (c < pbd_pkg::ROW_BYTES)
        begin
            rem = pbd_pkg::ROW_BYTES - c;
            if ((rem >= 2 || co_mode) && $urandom_range(0, 1))
            begin
                if (co_mode && (rem < 2 || $urandom_range(0, 5) == 0))
                    n = $urandom_range(rem + 1, MAX_RUN);
                else
                    n = size_pick(2, rem);
                send_byte(run_header(n));
                send_byte(pbd_pkg::BYTE_W'($urandom));
                c += (n > rem) ? rem : n;
            end
            else
            begin
                n = size_pick(1, rem);
                send_byte(lit_header(n));
                repeat (n) send_byte(pbd_pkg::BYTE_W'($urandom));
                c += n;
            end
        end
    endtask

    task automatic test_directed_rows();
        drain_decoder();
        write_config(1'b0, '1);
        // row 0: shortest run, single literal, short literal, run to the row end
        send_byte(run_header(2));
        send_byte(8'h00);
        send_byte(lit_header(1));
        send_byte(8'hFF);
        send_byte(lit_header(3));
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(run_header(pbd_pkg::ROW_BYTES - 6));
        send_byte(8'hAA);
        drain_decoder();
        write_config(1'b1, '1);
        // longest run overruns the row quietly, then an exact full-row run
        send_byte(run_header(MAX_RUN));
        send_byte(8'hFF);
        send_byte(run_header(pbd_pkg::ROW_BYTES));
        send_byte(8'h0F);
        drain_decoder();
        // stream length just covers a run, then just covers a literal
        write_config(1'b0, pbd_pkg::LEN_W'(int'(byte_total) + 2));
        send_byte(run_header(3));
        send_byte(8'h3C);
        drain_decoder();
        write_config(1'b0, pbd_pkg::LEN_W'(int'(byte_total) + 6));
        send_byte(lit_header(5));
        repeat (5) send_byte(pbd_pkg::BYTE_W'($urandom));
        drain_decoder();
        write_config(1'b0, '1);
        send_byte(run_header(pbd_pkg::ROW_BYTES - 8));
        send_byte(pbd_pkg::BYTE_W'($urandom));
    endtask

    task automatic test_random_rows();
        int i;
        int quota;
        logic co;
        for (i = 0; i < 6; i++)
        begin
            drain_decoder();
            co   = (i % 3 == 2);
            calm = (i == 3);
            if (i % 2 == 0)
                write_config(co, '1);
            else
                write_config(co, pbd_pkg::LEN_W'($urandom_range(int'(byte_total) + 400,
                                                     int'(pbd_pkg::CONSUMED_MAX))));
            quota = bytes_sent + PHASE_BYTES;
            while (bytes_sent < quota)
                send_row(co);
        end
        calm = 1'b0;
    endtask

    // hold the result side for a long stretch while items keep coming
    task automatic test_output_holdoff();
        drain_decoder();
        write_config(1'b0, '1);
        calm     = 1'b1;
        hold_len = HOLD_CYCLES;
        repeat (3) send_row(1'b0);
        calm = 1'b0;
    endtask

    task automatic test_terminal_event();
        ending_t kind;
        int      n;
        int      k;
        int      i;
        int      rows_left;
        logic    co;
        kind = ending_t'($urandom_range(0, 4));
        co   = 1'($urandom_range(0, 1));
        drain_decoder();
        case (kind)
            END_HEADER_TRUNC:
            begin
                if ($urandom_range(0, 1))
                    write_config(co, '0);
                else
                    write_config(co, pbd_pkg::LEN_W'($urandom_range(0,
                                                         int'(byte_total) + 1)));
                send_byte(pbd_pkg::BYTE_W'($urandom));
            end
            END_LITERAL_TRUNC:
            begin
                n = $urandom_range(1, MAX_RUN);
                write_config(co, pbd_pkg::LEN_W'($urandom_range(int'(byte_total) + 2,
                                                     int'(byte_total) + n + 1)));
                send_byte(pbd_pkg::BYTE_W'(n));
                repeat (n + 1) send_byte(pbd_pkg::BYTE_W'($urandom));
            end
            END_RUN_OVERFLOW:
            begin
                write_config(1'b0, '1);
                k = $urandom_range(0, pbd_pkg::ROW_BYTES - 1);
                if (k > 0)
                begin
                    send_byte(lit_header(k));
                    repeat (k) send_byte(pbd_pkg::BYTE_W'($urandom));
                end
                send_byte(run_header($urandom_range(pbd_pkg::ROW_BYTES - k + 1, MAX_RUN)));
                send_byte(pbd_pkg::BYTE_W'($urandom));
            end
            END_LITERAL_OVERFLOW:
            begin
                write_config(co, '1);
                n = $urandom_range(pbd_pkg::ROW_BYTES + 1, MAX_RUN + 1);
                send_byte(lit_header(n));
                repeat (n) send_byte(pbd_pkg::BYTE_W'($urandom));
            end
            default:
            begin
                // race through the remaining rows, two bytes per row
                write_config(1'b1, '1);
                rows_left = pbd_pkg::ROWS - int'(row_pos);
                for (i = 1; i < rows_left; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(run_header(pbd_pkg::ROW_BYTES));
                    else
                        send_byte(run_header($urandom_range(pbd_pkg::ROW_BYTES + 1,
                                                            MAX_RUN)));
                    send_byte(pbd_pkg::BYTE_W'($urandom));
                end
                if (co)
                begin
                    drain_decoder();
                    write_config(1'b0, '1);
                end
                send_byte(run_header(pbd_pkg::ROW_BYTES));
                send_byte(pbd_pkg::BYTE_W'($urandom));
            end
        endcase
    endtask

    // decoding has stopped: these items must pass without a result
    task automatic test_ignored_tail();
        repeat (12) send_byte(pbd_pkg::BYTE_W'($urandom));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_config(1'b0, '0);
        test_directed_rows();
        test_random_rows();
        test_output_holdoff();
        test_terminal_event();
        test_ignored_tail();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
